// File: sv/nass_pkg.sv
package nass_pkg;

  // Request opcodes.
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_START   = 2'd2;
  localparam logic [1:0] OP_CONSUME = 2'd3;

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_START  = 1'b0;
  localparam logic REG_ACCEPT = 1'b1;

  // Fixed field widths.
  localparam int FIELD_W    = 4;
  localparam int OUT_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int APB_W      = 32;

  // Sequencer state codes.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [ST_W-1:0] ST_CLEAR    = 3'd1;
  localparam logic [ST_W-1:0] ST_ADD_RD   = 3'd2;
  localparam logic [ST_W-1:0] ST_ADD_WR   = 3'd3;
  localparam logic [ST_W-1:0] ST_SYM      = 3'd4;
  localparam logic [ST_W-1:0] ST_SYM_TAIL = 3'd5;
  localparam logic [ST_W-1:0] ST_EPS      = 3'd6;
  localparam logic [ST_W-1:0] ST_EPS_TAIL = 3'd7;

endpackage

// File: sv/nfa_active_set_stepper.sv
// A clear sweeps every table row, an add reads and rewrites one row, a start runs the
// epsilon pass from the start state, and a consume runs a symbol pass, then an epsilon
// pass. Throughput: one request at a time; busy drops in the cycle that carries done,
// so the next request can be accepted there. One table row is read per cycle into a
// shared OR. Reset is synchronous and clears the tables with a sweep over every row
// with busy high; the one-cycle done strobe cannot be stalled by the receiver.
module nfa_active_set_stepper #(
  parameter int STATE_COUNT = 16,
  parameter int NUM_SYMBOLS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic [nass_pkg::FIELD_W-1:0]   symbol,
  input  logic [nass_pkg::FIELD_W-1:0]   src_state,
  input  logic [nass_pkg::FIELD_W-1:0]   dst_state,
  input  logic                           is_epsilon,
  output logic                           done,
  output logic [nass_pkg::OUT_W-1:0]     active_mask,
  output logic                           accepted,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nass_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nass_pkg::APB_W-1:0]     pwdata,
  output logic [nass_pkg::APB_W-1:0]     prdata,
  output logic                           pready
);
  import nass_pkg::*;

  localparam int SYM_DEPTH = STATE_COUNT * NUM_SYMBOLS;
  localparam int AW        = $clog2(SYM_DEPTH);
  localparam int SW        = $clog2(STATE_COUNT);
  localparam int EXT_W     = STATE_COUNT + OUT_W;
  localparam logic [AW-1:0] ADDR_LAST = AW'(SYM_DEPTH - 1);
  localparam logic [AW-1:0] ADDR_STEP = AW'(NUM_SYMBOLS);
  localparam logic [AW-1:0] NS_A      = AW'(STATE_COUNT);
  localparam logic [SW-1:0] IDX_LAST  = SW'(STATE_COUNT - 1);

  // Transition tables.
  logic [STATE_COUNT-1:0] sym_mem [SYM_DEPTH];
  logic [STATE_COUNT-1:0] eps_mem [STATE_COUNT];
  logic [STATE_COUNT-1:0] sym_rdata;
  logic [STATE_COUNT-1:0] eps_rdata;

  // Sequencer and datapath registers.
  logic [ST_W-1:0]        state;
  logic [AW-1:0]          addr;
  logic [SW-1:0]          idx;
  logic [STATE_COUNT-1:0] src;
  logic [STATE_COUNT-1:0] acc;
  logic [STATE_COUNT-1:0] active_set;
  logic                   hit_q;
  logic                   eps_q;
  logic                   use_eps;
  logic                   report;
  logic [FIELD_W-1:0]     start_state;
  logic [FIELD_W-1:0]     accept_idx;

  // Combinational helpers.
  logic [STATE_COUNT-1:0] acc_next;
  logic [STATE_COUNT-1:0] res_val;
  logic [EXT_W-1:0]       res_ext;
  logic                   res_acc;
  logic                   sym_ok;
  logic                   add_ok;
  logic                   start_ok;
  logic [AW-1:0]          add_addr;
  logic [STATE_COUNT-1:0] to_bit;
  logic [STATE_COUNT-1:0] start_bit;
  logic                   cfg_wr;
  logic                   sym_we;
  logic                   eps_we;
  logic [STATE_COUNT-1:0] sym_wdata;
  logic [STATE_COUNT-1:0] eps_wdata;
  logic [SW-1:0]          eps_waddr;

  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register readback.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ACCEPT) begin
      prdata[FIELD_W-1:0] = accept_idx;
    end else begin
      prdata[FIELD_W-1:0] = start_state;
    end
  end

  // Request decode: range checks and the row address of an added transition.
  assign sym_ok   = ({28'd0, symbol} < 32'(NUM_SYMBOLS));
  assign add_ok   = ({28'd0, src_state} < 32'(STATE_COUNT)) &&
                    ({28'd0, dst_state} < 32'(STATE_COUNT)) && (is_epsilon || sym_ok);
  assign start_ok = ({28'd0, start_state} < 32'(STATE_COUNT));
  assign add_addr = AW'(32'(src_state) * NUM_SYMBOLS + 32'(symbol));
  assign to_bit    = STATE_COUNT'(1) << dst_state;
  assign start_bit = start_ok ? (STATE_COUNT'(1) << start_state) : '0;

  // Shared OR accumulator fed by the row read in the previous cycle.
  assign acc_next = acc | (hit_q ? (eps_q ? eps_rdata : sym_rdata) : '0);

  // Result formatting: low state bits and the accept flag.
  assign res_val = (state == ST_EPS_TAIL) ? acc_next : active_set;
  assign res_ext = EXT_W'(res_val);
  assign res_acc = ({28'd0, accept_idx} < 32'(STATE_COUNT)) && res_val[SW'(accept_idx)];

  // Table write controls: clear sweep or read-modify-write of one row.
  assign sym_we    = (state == ST_CLEAR) || ((state == ST_ADD_WR) && !use_eps);
  assign sym_wdata = (state == ST_CLEAR) ? '0 : (sym_rdata | src);
  assign eps_we    = ((state == ST_CLEAR) && (addr < NS_A)) ||
                     ((state == ST_ADD_WR) && use_eps);
  assign eps_wdata = (state == ST_CLEAR) ? '0 : (eps_rdata | src);
  assign eps_waddr = (state == ST_CLEAR) ? addr[SW-1:0] : idx;

  // Symbol table memory.
  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[addr] <= sym_wdata;
    end
    sym_rdata <= sym_mem[addr];
  end

  // Epsilon table memory.
  always_ff @(posedge clk) begin
    if (eps_we) begin
      eps_mem[eps_waddr] <= eps_wdata;
    end
    eps_rdata <= eps_mem[idx];
  end

  // Result output registers.
  always_ff @(posedge clk) begin
    active_mask <= res_ext[OUT_W-1:0];
    accepted    <= res_acc;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      addr         <= '0;
      idx          <= '0;
      report       <= 1'b0;
      active_set   <= '0;
      done         <= 1'b0;
      hit_q        <= 1'b0;
      eps_q        <= 1'b0;
      use_eps      <= 1'b0;
      start_state  <= '0;
      accept_idx   <= '0;
    end else begin
      done  <= 1'b0;
      hit_q <= 1'b0;
      eps_q <= 1'b0;

      // Configuration writes.
      if (cfg_wr) begin
        if (paddr[2] == REG_ACCEPT) begin
          accept_idx <= pwdata[FIELD_W-1:0];
        end else begin
          start_state <= pwdata[FIELD_W-1:0];
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            unique case (op)
              OP_CLEAR: begin
                state      <= ST_CLEAR;
                addr       <= '0;
                report     <= 1'b1;
                active_set <= '0;
              end
              OP_ADD: begin
                // An invalid add rewrites row zero with its own value.
                state   <= ST_ADD_RD;
                addr    <= (add_ok && !is_epsilon) ? add_addr : '0;
                idx     <= add_ok ? SW'(src_state) : '0;
                src     <= add_ok ? to_bit : '0;
                use_eps <= is_epsilon;
              end
              OP_START: begin
                state <= ST_EPS;
                idx   <= '0;
                src   <= start_bit;
                acc   <= start_bit;
              end
              OP_CONSUME: begin
                state <= ST_SYM;
                idx   <= '0;
                addr  <= sym_ok ? AW'(symbol) : '0;
                src   <= sym_ok ? active_set : '0;
                acc   <= '0;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          addr <= addr + AW'(1);
          if (addr == ADDR_LAST) begin
            state  <= ST_IDLE;
            done   <= report;
            report <= 1'b0;
          end
        end
        ST_ADD_RD: begin
          state <= ST_ADD_WR;
        end
        ST_ADD_WR: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        ST_SYM: begin
          // Read row (idx, symbol); use it next cycle if idx is active.
          hit_q <= src[idx];
          acc   <= acc_next;
          addr  <= addr + ADDR_STEP;
          idx   <= idx + SW'(1);
          if (idx == IDX_LAST) begin
            state <= ST_SYM_TAIL;
          end
        end
        ST_SYM_TAIL: begin
          // The reached set gates the epsilon pass.
          acc   <= acc_next;
          src   <= acc_next;
          idx   <= '0;
          state <= ST_EPS;
        end
        ST_EPS: begin
          hit_q <= src[idx];
          eps_q <= 1'b1;
          acc   <= acc_next;
          idx   <= idx + SW'(1);
          if (idx == IDX_LAST) begin
            state <= ST_EPS_TAIL;
          end
        end
        ST_EPS_TAIL: begin
          active_set <= acc_next;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
      endcase
    end
  end

  // A result is only issued after the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");

  // Every accepted request leaves idle on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start the sequencer");

  // The active set stays empty throughout a clear sweep.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (active_set == '0))
    else $error("active set not empty during clear");

endmodule
